>>> hdl/clock_display_blink_ctrl_unit_assert.svh
// Assertion macros shared by the clock display blink control RTL.
`ifndef CLOCK_DISPLAY_BLINK_CTRL_UNIT_ASSERT_SVH
`define CLOCK_DISPLAY_BLINK_CTRL_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cdb_pkg.sv
// Types, constants and a helper function for the clock display blink control.
package cdb_pkg;

  localparam logic [3:0] BLANK_CODE = 4'd10;

  localparam logic [1:0] MODE_SHOW_ALL    = 2'd0;
  localparam logic [1:0] MODE_ADJ_HOURS   = 2'd1;
  localparam logic [1:0] MODE_ADJ_MINUTES = 2'd2;
  localparam logic [1:0] MODE_OTHER       = 2'd3;

  localparam logic [1:0] REG_REFRESH_PERIOD     = 2'd0;
  localparam logic [1:0] REG_FIELD_BLINK_PERIOD = 2'd1;
  localparam logic [1:0] REG_COLON_PERIOD       = 2'd2;
  localparam logic [1:0] REG_TICK_STEP          = 2'd3;

  localparam logic [7:0]  RESET_REFRESH_PERIOD     = 8'd20;
  localparam logic [15:0] RESET_FIELD_BLINK_PERIOD = 16'd500;
  localparam logic [15:0] RESET_COLON_PERIOD       = 16'd1000;
  localparam logic [7:0]  RESET_TICK_STEP          = 8'd5;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digit_pair_t;

  // Splits a value below 64 into tens and units: (v * 13) >> 7 equals v / 10
  // over that whole range.
  function automatic digit_pair_t split_digits(input logic [5:0] v);
    logic [12:0] prod;
    logic [3:0]  q;
    logic [6:0]  q10;
    digit_pair_t r;
    prod    = 13'(v) * 13'd13;
    q       = prod[10:7];
    q10     = 7'(q) * 7'd10;
    r.tens  = q;
    r.units = 4'(7'(v) - q10);
    return r;
  endfunction

endpackage

>>> hdl/clock_display_blink_ctrl_unit.sv
// Clock display blink control: tick-driven digit and colon dot update.
// An accepted tick is held in the input register; its result is held in the result register.
// Throughput: one tick per cycle while results are taken; the counters and digits are
// updated in the single compute stage between the input register and the result register.
// Reset clears the counters and digits to 0, turns the dot off and loads
// the default periods and tick step; no clearing pass is needed.
module clock_display_blink_ctrl_unit
  import cdb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [4:0] hours, [10:5] minutes, [15:11] zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] minute_units_digit, [7:4] minute_tens_digit, [11:8] hour_units_digit,
  // [15:12] hour_tens_digit, [16] dot_on, [23:17] zero
  output logic [23:0] m_tdata,
  output logic [0:0]  m_tuser,   // [0] refreshed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  refresh_period;
  logic [15:0] field_blink_period;
  logic [15:0] colon_period;
  logic [7:0]  tick_step;

  logic [7:0]  refresh_count, refresh_count_next;
  logic [15:0] dot_count, dot_count_next;
  logic [15:0] blink_count, blink_count_next;
  logic [3:0]  min_units, min_units_next;
  logic [3:0]  min_tens, min_tens_next;
  logic [3:0]  hr_units, hr_units_next;
  logic [3:0]  hr_tens, hr_tens_next;
  logic        dot_state, dot_state_next;

  logic        s1_valid;
  logic [4:0]  s1_hours;
  logic [5:0]  s1_minutes;
  logic [1:0]  s1_mode;

  logic        advance;
  logic        load;
  logic [7:0]  rc_add;
  logic [15:0] dc_add;
  logic [15:0] bc_add;
  logic        refresh_hit;
  digit_pair_t hr_split;
  digit_pair_t min_split;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period     <= RESET_REFRESH_PERIOD;
      field_blink_period <= RESET_FIELD_BLINK_PERIOD;
      colon_period       <= RESET_COLON_PERIOD;
      tick_step          <= RESET_TICK_STEP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REFRESH_PERIOD:     refresh_period     <= cfg_data[7:0];
        REG_FIELD_BLINK_PERIOD: field_blink_period <= cfg_data;
        REG_COLON_PERIOD:       colon_period       <= cfg_data;
        REG_TICK_STEP:          tick_step          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The result register frees the compute stage whenever it is empty or taken.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign load     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_hours   <= s_tdata[4:0];
      s1_minutes <= s_tdata[10:5];
      s1_mode    <= s_tuser;
    end
  end

  assign rc_add      = refresh_count + tick_step;
  assign dc_add      = dot_count + 16'(tick_step);
  assign bc_add      = blink_count + 16'(tick_step);
  assign refresh_hit = rc_add >= refresh_period;
  assign hr_split    = split_digits({1'b0, s1_hours});
  assign min_split   = split_digits(s1_minutes);

  always_comb begin
    refresh_count_next = rc_add;
    dot_count_next     = dc_add;
    blink_count_next   = bc_add;
    min_units_next     = min_units;
    min_tens_next      = min_tens;
    hr_units_next      = hr_units;
    hr_tens_next       = hr_tens;
    dot_state_next     = dot_state;
    if (refresh_hit) begin
      refresh_count_next = '0;
      case (s1_mode)
        MODE_SHOW_ALL: begin
          min_units_next   = min_split.units;
          min_tens_next    = min_split.tens;
          hr_units_next    = hr_split.units;
          hr_tens_next     = hr_split.tens;
          blink_count_next = '0;
          if (dc_add == colon_period) begin
            dot_count_next = '0;
            dot_state_next = !dot_state;
          end
        end
        MODE_ADJ_HOURS: begin
          min_units_next = min_split.units;
          min_tens_next  = min_split.tens;
          dot_state_next = 1'b0;
          dot_count_next = '0;
          if (bc_add == field_blink_period) begin
            blink_count_next = '0;
            // The field is treated as blank when its units code is blank.
            if (hr_units == BLANK_CODE) begin
              hr_units_next = hr_split.units;
              hr_tens_next  = hr_split.tens;
            end else begin
              hr_units_next = BLANK_CODE;
              hr_tens_next  = BLANK_CODE;
            end
          end
        end
        MODE_ADJ_MINUTES: begin
          hr_units_next  = hr_split.units;
          hr_tens_next   = hr_split.tens;
          dot_state_next = 1'b0;
          dot_count_next = '0;
          if (bc_add == field_blink_period) begin
            blink_count_next = '0;
            if (min_units == BLANK_CODE) begin
              min_units_next = min_split.units;
              min_tens_next  = min_split.tens;
            end else begin
              min_units_next = BLANK_CODE;
              min_tens_next  = BLANK_CODE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_count <= '0;
      dot_count     <= '0;
      blink_count   <= '0;
      min_units     <= '0;
      min_tens      <= '0;
      hr_units      <= '0;
      hr_tens       <= '0;
      dot_state     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= s1_valid;
      end
      if (load) begin
        refresh_count <= refresh_count_next;
        dot_count     <= dot_count_next;
        blink_count   <= blink_count_next;
        min_units     <= min_units_next;
        min_tens      <= min_tens_next;
        hr_units      <= hr_units_next;
        hr_tens       <= hr_tens_next;
        dot_state     <= dot_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {7'd0, dot_state_next, hr_tens_next, hr_units_next,
                  min_tens_next, min_units_next};
      m_tuser <= refresh_hit;
    end
  end

`include "clock_display_blink_ctrl_unit_assert.svh"

  `CDB_ASSERT_NEXT(a_refresh_clears, load && refresh_hit, refresh_count == 8'd0, "refresh count not cleared")
  `CDB_ASSERT_NEXT(a_no_refresh_adds, load && !refresh_hit, refresh_count == $past(rc_add), "refresh count not advanced")
  `CDB_ASSERT_NEXT(a_adjust_dot_off, load && refresh_hit && (s1_mode == MODE_ADJ_HOURS || s1_mode == MODE_ADJ_MINUTES), !dot_state && dot_count == 16'd0 && m_tdata[16] == 1'b0, "dot not cleared in adjust mode")
  `CDB_ASSERT_NEXT(a_result_flag, load, m_tvalid && m_tuser[0] == $past(refresh_hit), "refresh flag lost")
  `CDB_ASSERT_NOW(a_digit_range, m_tvalid, m_tdata[3:0] <= BLANK_CODE && m_tdata[7:4] <= BLANK_CODE && m_tdata[11:8] <= BLANK_CODE && m_tdata[15:12] <= BLANK_CODE, "digit code out of range")

endmodule

>>> bench/clock_display_blink_ctrl_unit_tb.sv
// Self-checking testbench for the clock display blink control unit.
`timescale 1ns / 1ps

module clock_display_blink_ctrl_unit_tb;
  import cdb_pkg::*;

  localparam int ITEMS_PER_PHASE = 115;
  localparam int RANDOM_PHASES   = 8;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic [3:0] hr_t;
    logic [3:0] hr_u;
    logic [3:0] min_t;
    logic [3:0] min_u;
    logic       dot_on;
    logic       refreshed;
  } display_t;

  // Tracks the display state tick by tick and checks each result transaction.
  class display_scoreboard;
    logic [7:0]  refresh_period;
    logic [15:0] field_period;
    logic [15:0] dot_period;
    logic [7:0]  step;
    logic [7:0]  refresh_cnt;
    logic [15:0] dot_cnt;
    logic [15:0] blink_cnt;
    logic [3:0]  min_u, min_t, hr_u, hr_t;
    logic        dot;
    display_t    expected_displays[$];
    int          errors;
    int          results_seen;

    function new();
      refresh_period = RESET_REFRESH_PERIOD;
      field_period   = RESET_FIELD_BLINK_PERIOD;
      dot_period     = RESET_COLON_PERIOD;
      step           = RESET_TICK_STEP;
      refresh_cnt    = '0;
      dot_cnt        = '0;
      blink_cnt      = '0;
      min_u          = '0;
      min_t          = '0;
      hr_u           = '0;
      hr_t           = '0;
      dot            = 1'b0;
      errors         = 0;
      results_seen   = 0;
    endfunction

    function int pending();
      return expected_displays.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_REFRESH_PERIOD:     refresh_period = data[7:0];
        REG_FIELD_BLINK_PERIOD: field_period = data;
        REG_COLON_PERIOD:       dot_period = data;
        REG_TICK_STEP:          step = data[7:0];
        default: ;
      endcase
    endfunction

    function void show_minutes(logic [5:0] m);
      min_u = 4'(m % 10);
      min_t = 4'(m / 10);
    endfunction

    function void show_hours(logic [4:0] h);
      hr_u = 4'(h % 10);
      hr_t = 4'(h / 10);
    endfunction

    function void note_tick(logic [4:0] hours, logic [5:0] minutes, logic [1:0] mode);
      display_t d;
      d.refreshed = 1'b0;
      refresh_cnt = refresh_cnt + step;
      dot_cnt     = dot_cnt + 16'(step);
      blink_cnt   = blink_cnt + 16'(step);
      if (refresh_cnt >= refresh_period) begin
        refresh_cnt = '0;
        d.refreshed = 1'b1;
        case (mode)
          MODE_SHOW_ALL: begin
            show_minutes(minutes);
            show_hours(hours);
            if (dot_cnt == dot_period) begin
              dot_cnt = '0;
              dot = !dot;
            end
            blink_cnt = '0;
          end
          MODE_ADJ_HOURS: begin
            show_minutes(minutes);
            dot = 1'b0;
            if (blink_cnt == field_period) begin
              blink_cnt = '0;
              if (hr_u == BLANK_CODE) begin
                show_hours(hours);
              end else begin
                hr_u = BLANK_CODE;
                hr_t = BLANK_CODE;
              end
            end
            dot_cnt = '0;
          end
          MODE_ADJ_MINUTES: begin
            show_hours(hours);
            dot = 1'b0;
            if (blink_cnt == field_period) begin
              blink_cnt = '0;
              if (min_u == BLANK_CODE) begin
                show_minutes(minutes);
              end else begin
                min_u = BLANK_CODE;
                min_t = BLANK_CODE;
              end
            end
            dot_cnt = '0;
          end
          default: ;
        endcase
      end
      d.min_u  = min_u;
      d.min_t  = min_t;
      d.hr_u   = hr_u;
      d.hr_t   = hr_t;
      d.dot_on = dot;
      expected_displays.push_back(d);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
      errors++;
    endtask

    task check_display(logic [23:0] data, logic [0:0] user);
      display_t want;
      results_seen++;
      if (expected_displays.size() == 0) begin
        report("result with nothing pending", data, 0);
        return;
      end
      want = expected_displays.pop_front();
      if (data[3:0] !== want.min_u) report("minute_units_digit", data[3:0], want.min_u);
      if (data[7:4] !== want.min_t) report("minute_tens_digit", data[7:4], want.min_t);
      if (data[11:8] !== want.hr_u) report("hour_units_digit", data[11:8], want.hr_u);
      if (data[15:12] !== want.hr_t) report("hour_tens_digit", data[15:12], want.hr_t);
      if (data[16] !== want.dot_on) report("dot_on", data[16], want.dot_on);
      if (user[0] !== want.refreshed) report("refreshed", user[0], want.refreshed);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  display_scoreboard sb;
  int burst_left;
  int run_left;
  int stall_left;
  int idle_cycles;
  bit tx_gaps;
  bit rx_stalls;

  clock_display_blink_ctrl_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sends one tick; bursts of random length are separated by random gaps when tx_gaps is set.
  task send_tick(input logic [4:0] h, input logic [5:0] m, input logic [1:0] md);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = tx_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, m, h};
    s_tuser  <= md;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_tick(h, m, md);
  endtask

  task stop_sending();
    s_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task wait_drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Writes all four registers back to back; the 8-bit ones get junk in the upper byte.
  task write_config(input int rp, input int fp, input int dp, input int ts);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    idx = '{REG_REFRESH_PERIOD, REG_FIELD_BLINK_PERIOD, REG_COLON_PERIOD, REG_TICK_STEP};
    val = '{{8'($urandom), 8'(rp)}, 16'(fp), 16'(dp), {8'($urandom), 8'(ts)}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [4:0] rand_hours();
    return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23));
  endfunction

  function automatic logic [5:0] rand_minutes();
    return ($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63)) : 6'($urandom_range(0, 59));
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 10);
    if (r < 4) return MODE_SHOW_ALL;
    if (r < 7) return MODE_ADJ_HOURS;
    if (r < 10) return MODE_ADJ_MINUTES;
    return MODE_OTHER;
  endfunction

  // Results are checked as they are taken; the ready pattern alternates runs and stalls when rx_stalls is set.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_display(m_tdata, m_tuser);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      m_tready <= 1'b1;
    end else begin
      run_left = $urandom_range(1, 16);
      if (!rx_stalls) stall_left = 0;
      else if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(10, 30);
      else stall_left = $urandom_range(0, 4);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("clock_display_blink_ctrl_unit test failed");
    $finish;
  end

  initial begin
    int s, k, span, rp, fp, dp, ts, seg_left;
    logic [1:0] seg_mode;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    run_left = 0;
    stall_left = 0;
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values: three ticks show zeros with the dot off, the fourth refreshes.
    repeat (4) send_tick(5'd23, 6'd59, MODE_SHOW_ALL);
    stop_sending();
    wait_drain();

    // Every tick refreshes, and in the adjust modes every blink period is met, so the adjusted field toggles each tick.
    write_config(1, 1, 1, 1);
    send_tick(5'd0, 6'd0, MODE_SHOW_ALL);
    send_tick(5'd23, 6'd59, MODE_SHOW_ALL);
    send_tick(5'd31, 6'd63, MODE_SHOW_ALL);
    send_tick(5'd24, 6'd60, MODE_SHOW_ALL);
    send_tick(5'd12, 6'd34, MODE_ADJ_HOURS);
    send_tick(5'd12, 6'd34, MODE_ADJ_HOURS);
    send_tick(5'd12, 6'd34, MODE_ADJ_HOURS);
    send_tick(5'd31, 6'd63, MODE_ADJ_HOURS);
    send_tick(5'd7, 6'd45, MODE_ADJ_MINUTES);
    send_tick(5'd7, 6'd45, MODE_ADJ_MINUTES);
    send_tick(5'd7, 6'd45, MODE_ADJ_MINUTES);
    send_tick(5'd30, 6'd62, MODE_ADJ_MINUTES);
    send_tick(5'd5, 6'd7, MODE_OTHER);
    send_tick(5'd19, 6'd33, MODE_OTHER);
    send_tick(5'd9, 6'd9, MODE_SHOW_ALL);
    send_tick(5'd10, 6'd10, MODE_SHOW_ALL);
    stop_sending();
    wait_drain();

    // Zero periods and a zero step: counters do not advance, every tick refreshes and every blink check is met.
    write_config(0, 0, 0, 0);
    send_tick(5'd21, 6'd58, MODE_SHOW_ALL);
    send_tick(5'd21, 6'd58, MODE_SHOW_ALL);
    send_tick(5'd21, 6'd58, MODE_ADJ_HOURS);
    send_tick(5'd21, 6'd58, MODE_ADJ_HOURS);
    send_tick(5'd3, 6'd17, MODE_ADJ_MINUTES);
    send_tick(5'd3, 6'd17, MODE_ADJ_MINUTES);
    stop_sending();
    wait_drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          rp = 255; fp = 65535; dp = 65535; ts = 255;
        end
        1: begin
          rp = 1; fp = 1; dp = 1; ts = 1;
        end
        4: begin
          rp = $urandom_range(1, 255);
          fp = $urandom_range(1, 65535);
          dp = $urandom_range(1, 65535);
          ts = $urandom_range(1, 255);
        end
        default: begin
          // Periods that are multiples of the refresh span, so the blink
          // counters land exactly on them at refresh ticks.
          s = $urandom_range(1, 60);
          k = $urandom_range(1, (255 / s < 4) ? 255 / s : 4);
          span = s * k;
          rp = span - $urandom_range(0, s - 1);
          fp = span * $urandom_range(1, 5);
          dp = span * $urandom_range(1, 5);
          ts = s;
        end
      endcase
      write_config(rp, fp, dp, ts);
      tx_gaps = (phase % 3 != 2);
      rx_stalls = (phase % 4 != 1);
      seg_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          stop_sending();
          wait_drain();
        end
        if (seg_left == 0) begin
          seg_mode = pick_mode();
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        send_tick(rand_hours(), rand_minutes(), seg_mode);
      end
      stop_sending();
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("clock_display_blink_ctrl_unit test passed");
    else
      $display("clock_display_blink_ctrl_unit test failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/cdb_pkg.sv
hdl/clock_display_blink_ctrl_unit.sv
bench/clock_display_blink_ctrl_unit_tb.sv
